// File: src/dltq_pkg.sv
// Package: shared types and constants of the delta-list timer queue.
package dltq_pkg;

  localparam int unsigned NumEntries = 32;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned LinkW      = 6;
  localparam logic [LinkW-1:0] NilLink = LinkW'(NumEntries);
  localparam logic [31:0]      MaxTimeout = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_DELETE = 2'd1,
    OP_MODIFY = 2'd2,
    OP_POLL   = 2'd3
  } op_e;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusInvalid = 2'd1;
  localparam logic [1:0] StatusNoTimer = 2'd2;

  localparam logic [1:0] EntFree    = 2'd0;
  localparam logic [1:0] EntActive  = 2'd1;
  localparam logic [1:0] EntExpired = 2'd2;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_DEC    = 12'b0000_0000_0010,
    ST_DWALK  = 12'b0000_0000_0100,
    ST_DFOLD  = 12'b0000_0000_1000,
    ST_DFREE  = 12'b0000_0001_0000,
    ST_SSTART = 12'b0000_0010_0000,
    ST_SPOP   = 12'b0000_0100_0000,
    ST_SWALK  = 12'b0000_1000_0000,
    ST_SLINK  = 12'b0001_0000_0000,
    ST_SLINK2 = 12'b0010_0000_0000,
    ST_PCHK   = 12'b0100_0000_0000,
    ST_DONE   = 12'b1000_0000_0000
  } state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  handle;
    logic [31:0] timeout_ms;
    logic [7:0]  event_sink;
    logic [31:0] user_argument;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  new_handle;
    logic        expired;
    logic [5:0]  expired_handle;
    logic [7:0]  expired_sink;
    logic [31:0] expired_argument;
    logic [5:0]  free_count;
    logic [5:0]  min_free_seen;
  } rsp_t;

endpackage

// File: src/dltq_if.sv
// Interfaces: request and response channels of the timer queue.
interface dltq_req_if;
  logic             valid;
  logic             ready;
  dltq_pkg::req_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dltq_rsp_if;
  logic             valid;
  logic             ready;
  dltq_pkg::rsp_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/delta_list_timer_queue_unit.sv
// Top level: delta-list timer queue with list state held in synchronous memories.
// Poll checks the head entry; delete walks the active list entry by entry, then frees;
// set pops a free entry and walks to its place; modify is delete then set.
// One operation is in flight at a time; the list walk in memory sets the rate.
// A result waits in an output register while the next beat is accepted.
// Reset: empty active list, all entries free and chained in index order.
module delta_list_timer_queue_unit (
  input  logic clk_i,
  input  logic rst_ni,
  dltq_req_if.sink   req,
  dltq_rsp_if.source rsp
);
  import dltq_pkg::*;

  // control and payload registers
  state_e             state_q, state_d;
  req_t               cmd_q, cmd_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [LinkW-1:0]   cur_q, cur_d, prev_q, prev_d;
  logic [31:0]        nd_q, nd_d, dacc_q, dacc_d;
  logic [LinkW-1:0]   head_q, head_d, fhead_q, fhead_d;
  logic [31:0]        base_q, base_d;
  logic [5:0]         ftot_q, ftot_d, flow_q, flow_d;
  logic [1:0]         status_q, status_d;
  logic [5:0]         nh_q, nh_d, eh_q, eh_d;
  logic               exp_q, exp_d;
  logic [7:0]         es_q, es_d;
  logic [31:0]        ea_q, ea_d;
  rsp_t               out_q, out_d;
  logic               ovld_q, ovld_d;

  // memories and read registers
  logic [LinkW-1:0]   link_mem [NumEntries];
  logic [31:0]        delta_mem [NumEntries];
  logic [7:0]         sink_mem [NumEntries];
  logic [31:0]        arg_mem [NumEntries];
  logic [NumEntries-1:0] lvld_q;
  logic [1:0]         est_q [NumEntries];

  logic [IdxW-1:0]    rd_addr, rd_addr_q;
  logic [LinkW-1:0]   lmem_rd_q, lnk_rd;
  logic               lvld_rd_q;
  logic [31:0]        dlt_rd_q;
  logic [7:0]         snk_rd_q;
  logic [31:0]        arg_rd_q;

  logic               lw_en, dw_en, pw_en, ew_en;
  logic [IdxW-1:0]    lw_addr, dw_addr, ew_addr;
  logic [LinkW-1:0]   lw_data;
  logic [31:0]        dw_data;
  logic [1:0]         ew_data;

  logic [LinkW-1:0]   hnd_m1;
  logic [31:0]        elapsed;

  assign req.ready = (state_q == ST_IDLE);
  assign rsp.valid = ovld_q;
  assign rsp.data  = out_q;

  // link not yet written reads as the reset chain
  assign lnk_rd  = lvld_rd_q ? lmem_rd_q : ({1'b0, rd_addr_q} + LinkW'(1));
  assign hnd_m1  = cmd_q.handle - 6'd1;
  assign elapsed = cmd_q.now_ms - base_q;

  // sequencer
  always_comb begin
    state_d  = state_q;  cmd_d   = cmd_q;   idx_d   = idx_q;
    cur_d    = cur_q;    prev_d  = prev_q;  nd_d    = nd_q;   dacc_d = dacc_q;
    head_d   = head_q;   fhead_d = fhead_q; base_d  = base_q;
    ftot_d   = ftot_q;   flow_d  = flow_q;
    status_d = status_q; nh_d    = nh_q;    exp_d   = exp_q;
    eh_d     = eh_q;     es_d    = es_q;    ea_d    = ea_q;
    out_d    = out_q;    ovld_d  = ovld_q;
    rd_addr  = cur_q[IdxW-1:0];
    lw_en = 1'b0; lw_addr = idx_q; lw_data = fhead_q;
    dw_en = 1'b0; dw_addr = idx_q; dw_data = nd_q;
    pw_en = 1'b0;
    ew_en = 1'b0; ew_addr = idx_q; ew_data = EntFree;

    if (ovld_q && rsp.ready) ovld_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req.valid) begin
          cmd_d = req.data;
          status_d = StatusOk; nh_d = '0; exp_d = 1'b0;
          eh_d = '0; es_d = '0; ea_d = '0;
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        cur_d  = head_q;
        prev_d = NilLink;
        rd_addr = head_q[IdxW-1:0];
        case (op_e'(cmd_q.opcode))
          OP_SET: state_d = ST_SSTART;
          OP_POLL: state_d = (head_q == NilLink) ? ST_DONE : ST_PCHK;
          default: begin
            idx_d = hnd_m1[IdxW-1:0];
            if (cmd_q.handle == '0) begin
              state_d = (op_e'(cmd_q.opcode) == OP_MODIFY) ? ST_SSTART : ST_DONE;
            end else if (cmd_q.handle > 6'(NumEntries)) begin
              status_d = StatusInvalid;
              state_d  = ST_DONE;
            end else begin
              case (est_q[hnd_m1[IdxW-1:0]])
                EntFree: begin
                  status_d = StatusInvalid;
                  state_d  = ST_DONE;
                end
                EntActive: state_d = (head_q == NilLink) ? ST_DFREE : ST_DWALK;
                default:   state_d = ST_DFREE;
              endcase
            end
          end
        endcase
      end
      ST_DWALK: begin
        if (cur_q[IdxW-1:0] == idx_q) begin
          // unlink target, carry its delta to the successor
          if (prev_q == NilLink) begin
            head_d = lnk_rd;
          end else begin
            lw_en = 1'b1; lw_addr = prev_q[IdxW-1:0]; lw_data = lnk_rd;
          end
          dacc_d  = dlt_rd_q;
          cur_d   = lnk_rd;
          rd_addr = lnk_rd[IdxW-1:0];
          state_d = (lnk_rd == NilLink) ? ST_DFREE : ST_DFOLD;
        end else begin
          prev_d  = cur_q;
          cur_d   = lnk_rd;
          rd_addr = lnk_rd[IdxW-1:0];
          if (lnk_rd == NilLink) state_d = ST_DFREE;
        end
      end
      ST_DFOLD: begin
        dw_en = 1'b1; dw_addr = cur_q[IdxW-1:0]; dw_data = dlt_rd_q + dacc_q;
        state_d = ST_DFREE;
      end
      ST_DFREE: begin
        // return entry to the free pool
        ew_en = 1'b1; ew_data = EntFree;
        lw_en = 1'b1; lw_addr = idx_q; lw_data = fhead_q;
        fhead_d = {1'b0, idx_q};
        ftot_d  = ftot_q + 6'd1;
        state_d = (op_e'(cmd_q.opcode) == OP_MODIFY) ? ST_SSTART : ST_DONE;
      end
      ST_SSTART: begin
        rd_addr = fhead_q[IdxW-1:0];
        idx_d   = fhead_q[IdxW-1:0];
        nd_d    = elapsed + cmd_q.timeout_ms;
        if (cmd_q.timeout_ms > MaxTimeout || ftot_q == '0) begin
          status_d = StatusNoTimer;
          state_d  = ST_DONE;
        end else begin
          state_d = ST_SPOP;
        end
      end
      ST_SPOP: begin
        fhead_d = lnk_rd;
        ftot_d  = ftot_q - 6'd1;
        if (flow_q > ftot_q - 6'd1) flow_d = ftot_q - 6'd1;
        pw_en = 1'b1;
        ew_en = 1'b1; ew_data = EntActive;
        nh_d  = {1'b0, idx_q} + 6'd1;
        cur_d = head_q; prev_d = NilLink;
        rd_addr = head_q[IdxW-1:0];
        state_d = (head_q == NilLink) ? ST_SLINK : ST_SWALK;
      end
      ST_SWALK: begin
        if (dlt_rd_q > nd_q) begin
          dw_en = 1'b1; dw_addr = cur_q[IdxW-1:0]; dw_data = dlt_rd_q - nd_q;
          state_d = ST_SLINK;
        end else begin
          nd_d    = nd_q - dlt_rd_q;
          prev_d  = cur_q;
          cur_d   = lnk_rd;
          rd_addr = lnk_rd[IdxW-1:0];
          if (lnk_rd == NilLink) state_d = ST_SLINK;
        end
      end
      ST_SLINK: begin
        dw_en = 1'b1; dw_addr = idx_q; dw_data = nd_q;
        lw_en = 1'b1; lw_addr = idx_q; lw_data = cur_q;
        if (prev_q == NilLink) begin
          head_d  = {1'b0, idx_q};
          state_d = ST_DONE;
        end else begin
          state_d = ST_SLINK2;
        end
      end
      ST_SLINK2: begin
        lw_en = 1'b1; lw_addr = prev_q[IdxW-1:0]; lw_data = {1'b0, idx_q};
        state_d = ST_DONE;
      end
      ST_PCHK: begin
        if (elapsed >= dlt_rd_q) begin
          head_d = lnk_rd;
          base_d = base_q + dlt_rd_q;
          ew_en = 1'b1; ew_addr = head_q[IdxW-1:0]; ew_data = EntExpired;
          exp_d = 1'b1;
          eh_d  = head_q + 6'd1;
          es_d  = snk_rd_q;
          ea_d  = arg_rd_q;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!ovld_q || rsp.ready) begin
          out_d.status           = status_q;
          out_d.new_handle       = nh_q;
          out_d.expired          = exp_q;
          out_d.expired_handle   = eh_q;
          out_d.expired_sink     = es_q;
          out_d.expired_argument = ea_q;
          out_d.free_count       = ftot_q;
          out_d.min_free_seen    = flow_q;
          ovld_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= NilLink;
      fhead_q <= '0;
      base_q  <= '0;
      ftot_q  <= 6'(NumEntries);
      flow_q  <= 6'(NumEntries);
      ovld_q  <= 1'b0;
      lvld_q  <= '0;
      for (int i = 0; i < NumEntries; i++) est_q[i] <= EntFree;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fhead_q <= fhead_d;
      base_q  <= base_d;
      ftot_q  <= ftot_d;
      flow_q  <= flow_d;
      ovld_q  <= ovld_d;
      if (lw_en) lvld_q[lw_addr] <= 1'b1;
      if (ew_en) est_q[ew_addr] <= ew_data;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;  idx_q <= idx_d;  cur_q <= cur_d;  prev_q <= prev_d;
    nd_q <= nd_d;    dacc_q <= dacc_d;
    status_q <= status_d; nh_q <= nh_d; exp_q <= exp_d;
    eh_q <= eh_d;    es_q <= es_d;    ea_q <= ea_d;
    out_q <= out_d;
  end

  // entry memories, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (lw_en) link_mem[lw_addr] <= lw_data;
    lmem_rd_q <= link_mem[rd_addr];
    lvld_rd_q <= lvld_q[rd_addr] && !(lw_en && lw_addr == rd_addr) ? 1'b1
                 : lvld_q[rd_addr];
    rd_addr_q <= rd_addr;
  end

  always_ff @(posedge clk_i) begin
    if (dw_en) delta_mem[dw_addr] <= dw_data;
    dlt_rd_q <= delta_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pw_en) begin
      sink_mem[idx_q] <= cmd_q.event_sink;
      arg_mem[idx_q]  <= cmd_q.user_argument;
    end
    snk_rd_q <= sink_mem[rd_addr];
    arg_rd_q <= arg_mem[rd_addr];
  end

`ifndef ASSERT_OFF
  a_ftot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ftot_q <= 6'(NumEntries)) else $error("free count above pool size");
  a_low_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flow_q <= ftot_q) else $error("low mark above free count");
  a_empty_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ftot_q == '0) |-> (fhead_q == NilLink)) else $error("empty pool with free head");
  a_accept_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> (state_q == ST_DEC)) else $error("accept not decoded");
  a_done_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !ovld_q) |=> (ovld_q && state_q == ST_IDLE))
    else $error("result not loaded");
`endif

endmodule
